// File: rtl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// shared types and constants of the inertial sensor frame parser
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int PACKET_BYTES_DEF = 11;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_BITS    = 53;
    localparam int OUT_BYTES_W = 56;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_BAD_SUM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    // raw frame record handed from the collector to the decoder
    typedef struct packed {
        logic [7:0]  type_byte;
        logic        sum_ok;
        logic [15:0] val_x;
        logic [15:0] val_y;
        logic [15:0] val_z;
    } frame_rec_t;

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } frame_push_t;

endpackage

// File: rtl/ifp_front.sv
// ----------------------------------------------------------------------------
// ifp_front
// hunts for the header, collects a frame and keeps the running sum
// ----------------------------------------------------------------------------
module ifp_front
    import ifp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        q_full,
    output frame_push_t q_wr
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       type_reg;
    logic [7:0]       val_reg [0:5];
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        q_wr.push  = 1'b0;
        q_wr.rec.type_byte = type_reg;
        q_wr.rec.sum_ok    = (sum_reg == in_byte);
        q_wr.rec.val_x     = {val_reg[1], val_reg[0]};
        q_wr.rec.val_y     = {val_reg[3], val_reg[2]};
        q_wr.rec.val_z     = {val_reg[5], val_reg[4]};
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                if (in_byte == HDR_BYTE)
                begin
                    pos_next = POS_W'(1);
                    sum_next = in_byte;
                end
            end
            else if (pos_reg == LAST_POS)
            begin
                q_wr.push = 1'b1;
                pos_next  = '0;
                sum_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                sum_next = sum_reg + in_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // frame bytes 1 to 7: type byte and the three little-endian values
    always_ff @(posedge clk)
    begin
        if (accept && pos_reg == POS_W'(1))
        begin
            type_reg <= in_byte;
        end
        for (int i = 0; i < 6; i++)
        begin
            if (accept && pos_reg == POS_W'(i + 2))
            begin
                val_reg[i] <= in_byte;
            end
        end
    end

endmodule

// File: rtl/ifp_queue.sv
// ----------------------------------------------------------------------------
// ifp_queue
// short queue of finished frame records between collector and decoder
// ----------------------------------------------------------------------------
module ifp_queue
    import ifp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_push_t wr,
    output logic        full,
    output logic        rd_valid,
    input  logic        rd_pop,
    output frame_rec_t  rd_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr.push && !full;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_rec   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr.rec;
        end
    end

endmodule

// File: rtl/ifp_back.sv
// ----------------------------------------------------------------------------
// ifp_back
// checks type and checksum of a frame record and holds the result item
// ----------------------------------------------------------------------------
module ifp_back
    import ifp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  frame_rec_t             q_rec,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_BYTES_W-1:0] out_data
);

    logic                   valid_reg;
    logic [OUT_BYTES_W-1:0] data_reg;
    logic [OUT_BITS-1:0]    data_next;
    status_t                status;
    kind_t                  kind;
    logic                   known;

    assign q_pop     = q_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        known = 1'b1;
        kind  = KIND_ACC;
        unique case (q_rec.type_byte)
            TYPE_ACC:   kind = KIND_ACC;
            TYPE_RATE:  kind = KIND_RATE;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:    known = 1'b0;
        endcase
        if (!known)
        begin
            status = ST_BAD_TYPE;
        end
        else if (!q_rec.sum_ok)
        begin
            status = ST_BAD_SUM;
        end
        else
        begin
            status = ST_GOOD;
        end
        if (status == ST_GOOD)
        begin
            data_next = {(kind == KIND_ANGLE), q_rec.val_z, q_rec.val_y, q_rec.val_x,
                         kind, status};
        end
        else
        begin
            data_next = {{(OUT_BITS - 2){1'b0}}, status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= {{(OUT_BYTES_W - OUT_BITS){1'b0}}, data_next};
        end
    end

endmodule

// File: rtl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// serial frame parser for an inertial sensor with an 8-bit additive checksum
// ----------------------------------------------------------------------------
// s_axis carries one received serial byte per item. while hunting, every
// byte other than the 0x55 header is dropped; a header starts a frame of
// PACKET_BYTES bytes. the last byte of a frame produces one item on m_axis
// with status, kind, three raw signed axis codes and the angle flag.
// a byte is taken in every cycle while the two-entry record queue has room;
// the result of a frame is written into the queue when its last byte is
// accepted and then moves on to the output register of m_axis. the collector
// sets the rate of one byte per cycle; a stalled m_axis fills the output
// register and then the queue, after which s_axis_tready drops until an item
// is taken.
// bytes of a frame keep being accepted as long as the queue is not full.
// reset returns the collector to hunting and empties queue and output.
// ----------------------------------------------------------------------------
module imu_frame_parser
    import ifp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata   // status, kind, value_x, value_y,
                                                  // value_z, angle_ready
);

    frame_push_t q_wr;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    frame_rec_t  q_rec;

    ifp_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    ifp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_rec   (q_rec)
    );

    ifp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_rec     (q_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: verif/imu_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_tb
// self-checking testbench of the inertial sensor frame parser
// ----------------------------------------------------------------------------
// serial bytes are driven on s_axis: a few hand-built frames first, then
// mostly well-formed frames with random content, mixed with noise while
// hunting, bad type bytes, bad checksums and raw byte runs. a frame model
// in a small scoreboard class predicts one result per completed frame,
// and every m_axis item is compared field by field with the oldest one.
// the run goes through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module imu_frame_parser_tb
    import ifp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN    = PACKET_BYTES_DEF;
    localparam int TARGET_BYTES = 1150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic        angle_ready;
        logic [15:0] value_z;
        logic [15:0] value_y;
        logic [15:0] value_x;
        kind_t       kind;
        status_t     status;
    } imu_result_t;

    class imu_frame_model;
        logic [7:0]  frame_bytes [FRAME_LEN];
        int          byte_idx;
        logic [7:0]  byte_sum;
        imu_result_t expected_q [$];
        int          errors;

        function new();
            byte_idx = 0;
            byte_sum = '0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b);
            imu_result_t res;
            logic [7:0]  type_byte;
            logic        known;
            if (byte_idx == 0 && b != HDR_BYTE)
                return;
            frame_bytes[byte_idx] = b;
            byte_idx++;
            if (byte_idx < FRAME_LEN)
            begin
                byte_sum += b;
                return;
            end
            type_byte = frame_bytes[1];
            known = (type_byte == TYPE_ACC) || (type_byte == TYPE_RATE) ||
                    (type_byte == TYPE_ANGLE);
            res = '0;
            if (!known)
                res.status = ST_BAD_TYPE;
            else if (byte_sum != b)
                res.status = ST_BAD_SUM;
            else
            begin
                res.status      = ST_GOOD;
                res.kind        = kind_t'(type_byte[1:0] - TYPE_ACC[1:0]);
                res.value_x     = {frame_bytes[3], frame_bytes[2]};
                res.value_y     = {frame_bytes[5], frame_bytes[4]};
                res.value_z     = {frame_bytes[7], frame_bytes[6]};
                res.angle_ready = (res.kind == KIND_ANGLE);
            end
            expected_q.push_back(res);
            byte_idx = 0;
            byte_sum = '0;
        endfunction

        function void check_result(logic [OUT_BYTES_W-1:0] data);
            imu_result_t got;
            imu_result_t exp_res;
            got = data[OUT_BITS-1:0];
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item, tdata %h", data);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.status != exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, got.status);
                errors++;
            end
            if (got.kind != exp_res.kind)
            begin
                $error("kind: expected %0d, actual %0d", exp_res.kind, got.kind);
                errors++;
            end
            if (got.value_x != exp_res.value_x)
            begin
                $error("value_x: expected %0d, actual %0d",
                       $signed(exp_res.value_x), $signed(got.value_x));
                errors++;
            end
            if (got.value_y != exp_res.value_y)
            begin
                $error("value_y: expected %0d, actual %0d",
                       $signed(exp_res.value_y), $signed(got.value_y));
                errors++;
            end
            if (got.value_z != exp_res.value_z)
            begin
                $error("value_z: expected %0d, actual %0d",
                       $signed(exp_res.value_z), $signed(got.value_z));
                errors++;
            end
            if (got.angle_ready != exp_res.angle_ready)
            begin
                $error("angle_ready: expected %0d, actual %0d",
                       exp_res.angle_ready, got.angle_ready);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;

    imu_frame_model model = new();
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             bytes_sent = 0;
    int             cycle_count = 0;

    imu_frame_parser #(
        .PACKET_BYTES (FRAME_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_result(m_axis_tdata);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        model.note_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic [15:0] tail, input logic [7:0] sum_err);
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] sum;
        fb[0] = HDR_BYTE;
        fb[1] = type_byte;
        {fb[3], fb[2]} = x;
        {fb[5], fb[4]} = y;
        {fb[7], fb[6]} = z;
        for (int i = 8; i < FRAME_LEN - 1; i++)
            fb[i] = (i == 8) ? tail[7:0] : (i == 9) ? tail[15:8] : 8'($urandom);
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            sum += fb[i];
        fb[FRAME_LEN-1] = sum ^ sum_err;
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(fb[i]);
        bytes_sent += FRAME_LEN;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 99) < 88)
            return TYPE_ACC + 8'($urandom_range(0, 2));
        return 8'($urandom);
    endfunction

    task automatic random_item();
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // noise while hunting
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                b = 8'($urandom);
                if (b == HDR_BYTE)
                    b = 8'h54;
                send_byte(b);
            end
        end
        else if (r < 12)
        begin
            // raw run that may break frame alignment
            n = $urandom_range(1, FRAME_LEN + 3);
            repeat (n)
                send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom));
            bytes_sent += n;
        end
        else
        begin
            send_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(), 16'($urandom),
                       ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 99) < 2)
            wait_drain();
    endtask

    initial
    begin
        int phase_target;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: noise, header inside a frame, extremes, bad sum, bad type
        send_byte(8'h00);
        send_byte(8'hff);
        send_frame(TYPE_RATE, 16'h7fff, 16'h8000, 16'h0055, 16'h5555, 8'h00);
        send_frame(TYPE_ANGLE, 16'h8000, 16'hffff, 16'h7fff, 16'h0000, 8'h01);
        send_frame(8'h54, 16'h0000, 16'h1234, 16'hffff, 16'haaaa, 8'h80);
        wait_drain();

        phase_target = (TARGET_BYTES - bytes_sent) / 4;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < phase_target)
                random_item();
            wait_drain();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES * 2)
            @(posedge clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
